// ----- hw/rtl/ppe_pkg.sv -----
// Package: shared types, sample codes, run slot codes and the ETU-to-sample table.
`timescale 1ns / 1ps
package ppe_pkg;

  // Sample byte codes
  localparam logic [7:0] SV_HEADER  = 8'h24;
  localparam logic [7:0] SV_CARRIER = 8'h00;
  localparam logic [7:0] SV_PAUSE   = 8'h08;

  localparam logic [4:0] HEADER_LEN = 5'd1;
  localparam logic [4:0] PAUSE_LEN  = 5'd2;
  localparam logic [1:0] PAIR_MASK  = 2'b11;

  // Run slots of a full frame: start-of-frame, four pairs, end-of-frame
  localparam logic [3:0] SLOT_HEADER       = 4'd0;
  localparam logic [3:0] SLOT_SOF_PAUSE0   = 4'd1;
  localparam logic [3:0] SLOT_SOF_CARRIER  = 4'd2;
  localparam logic [3:0] SLOT_SOF_PAUSE1   = 4'd3;
  localparam logic [3:0] SLOT_PAIR0_RUN    = 4'd4;
  localparam logic [3:0] SLOT_PAIR0_PAUSE  = 4'd5;
  localparam logic [3:0] SLOT_PAIR1_RUN    = 4'd6;
  localparam logic [3:0] SLOT_PAIR1_PAUSE  = 4'd7;
  localparam logic [3:0] SLOT_PAIR2_RUN    = 4'd8;
  localparam logic [3:0] SLOT_PAIR2_PAUSE  = 4'd9;
  localparam logic [3:0] SLOT_PAIR3_RUN    = 4'd10;
  localparam logic [3:0] SLOT_PAIR3_PAUSE  = 4'd11;
  localparam logic [3:0] SLOT_EOF_CARRIER0 = 4'd12;
  localparam logic [3:0] SLOT_EOF_PAUSE    = 4'd13;
  localparam logic [3:0] SLOT_EOF_CARRIER1 = 4'd14;

  // Fixed ETU counts
  localparam logic [3:0] SOF_ETUS  = 4'd4;
  localparam logic [3:0] FIRST_BASE_ETUS = 4'd3;
  localparam logic [3:0] PAIR_BASE_ETUS  = 4'd7;
  localparam logic [3:0] EOF_BASE_ETUS   = 4'd8;
  localparam logic [3:0] EOF_TAIL_ETUS   = 4'd1;

  // round(n * 2.18) for n = 0..15
  localparam logic [5:0] ETU_SAMPLES [16] = '{
    6'd0, 6'd2, 6'd4, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15,
    6'd17, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd31, 6'd33
  };

  // One byte being expanded, with the frame state it entered with
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last_byte;
    logic       started;
    logic [1:0] prev_pair;
  } item_t;

  // One run result
  typedef struct packed {
    logic [7:0] sample_value;
    logic [4:0] run_length;
    logic       frame_end;
    logic       run_last;
  } run_t;

endpackage

// ----- hw/rtl/ppe_in_if.sv -----
// Interface: command byte channel (valid/ready handshake).
`timescale 1ns / 1ps
interface ppe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       last_byte;

  modport source (output valid, output cmd_byte, output last_byte, input ready);
  modport sink   (input valid, input cmd_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/ppe_out_if.sv -----
// Interface: run result channel (valid/ready handshake).
`timescale 1ns / 1ps
interface ppe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_value;
  logic [4:0] run_length;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, output sample_value, output run_length,
                  output frame_end, output run_last, input ready);
  modport sink   (input valid, input sample_value, input run_length,
                  input frame_end, input run_last, output ready);
endinterface

// ----- hw/rtl/pulse_position_1of4_encoder.sv -----
// Top level: 1-out-of-4 pulse position encoder producing a run-length sample stream.
//
//   channel | dir | payload                                       | beat
//   cmd     | in  | cmd_byte[7:0], last_byte                      | one command byte
//   run     | out | sample_value[7:0], run_length[4:0], frame_end, | one run of samples
//           |     | run_last                                      |
//
// A byte expands into 8 runs, 12 if it opens a frame, 11 if it closes one, 15 if both.
// The slot counter hands one run a cycle to the output register unless a stall on run holds it;
// the next byte is taken in the cycle its predecessor's last run moves out.
// Reset (rst, synchronous) empties both registers and closes any open frame.
// A stall on run holds the output register and, behind it, the slot counter.
`timescale 1ns / 1ps
module pulse_position_1of4_encoder (
  input  logic     clk,
  input  logic     rst,
  ppe_in_if.sink   cmd,
  ppe_out_if.source run
);

  // Frame state carried between bytes
  logic           frame_started;
  logic [1:0]     previous_pair;

  // Work register: the byte being expanded
  logic           work_valid;
  logic [3:0]     work_slot;
  ppe_pkg::item_t work_item;

  // Output register
  logic           out_valid;
  ppe_pkg::run_t  out_run;

  ppe_pkg::run_t  run_next;
  logic           run_is_last;
  logic           out_load;
  logic           cmd_acc;
  logic [3:0]     last_slot;

  assign last_slot   = work_item.last_byte ? ppe_pkg::SLOT_EOF_CARRIER1
                                           : ppe_pkg::SLOT_PAIR3_PAUSE;
  assign run_is_last = (work_slot == last_slot);
  assign out_load    = work_valid && (!out_valid || run.ready);
  assign cmd.ready   = !work_valid || (out_load && run_is_last);
  assign cmd_acc     = cmd.valid && cmd.ready;

  ppe_run_gen u_run_gen (
    .item    (work_item),
    .slot    (work_slot),
    .is_last (run_is_last),
    .run     (run_next)
  );

  // Control: valid flags, slot counter, frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid    <= 1'b0;
      work_slot     <= ppe_pkg::SLOT_HEADER;
      out_valid     <= 1'b0;
      frame_started <= 1'b0;
      previous_pair <= 2'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (run.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_acc) begin
        work_valid    <= 1'b1;
        work_slot     <= frame_started ? ppe_pkg::SLOT_PAIR0_RUN : ppe_pkg::SLOT_HEADER;
        frame_started <= !cmd.last_byte;
        previous_pair <= cmd.cmd_byte[7:6];
      end else if (out_load && run_is_last) begin
        work_valid <= 1'b0;
      end else if (out_load) begin
        work_slot <= work_slot + 4'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      work_item.cmd_byte  <= cmd.cmd_byte;
      work_item.last_byte <= cmd.last_byte;
      work_item.started   <= frame_started;
      work_item.prev_pair <= previous_pair;
    end
    if (out_load) begin
      out_run <= run_next;
    end
  end

  assign run.valid        = out_valid;
  assign run.sample_value = out_run.sample_value;
  assign run.run_length   = out_run.run_length;
  assign run.frame_end    = out_run.frame_end;
  assign run.run_last     = out_run.run_last;

  // A new byte only enters when the work register is free or draining its last run
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |-> (!work_valid || (out_load && run_is_last)))
    else $error("byte accepted while previous byte still expanding");

  // Slot counter never runs past the final end-of-frame run
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> (work_slot <= ppe_pkg::SLOT_EOF_CARRIER1))
    else $error("slot counter out of range");

  // The frame's final run is always the byte's last run
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_run.frame_end) |-> out_run.run_last)
    else $error("frame_end without run_last");

  // A loaded run is presented in the next cycle with a nonzero length
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (out_run.run_length != 5'd0)))
    else $error("loaded run not presented");

  // Closing a frame clears the frame state
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && cmd.last_byte) |=> !frame_started)
    else $error("frame left open after last byte");

endmodule

// ----- hw/rtl/ppe_run_gen.sv -----
// Run generator: forms one run result from the held byte and its slot number.
`timescale 1ns / 1ps
module ppe_run_gen (
  input  ppe_pkg::item_t item,
  input  logic [3:0]     slot,
  input  logic           is_last,
  output ppe_pkg::run_t  run
);

  logic [2:0] pair_idx;
  logic [1:0] pair;
  logic [1:0] prev;
  logic [3:0] pair_etus;
  logic [3:0] eof_etus;
  logic [5:0] pair_samples;
  logic [5:0] eof_samples;
  logic [5:0] sof_samples;
  logic [5:0] tail_samples;

  // Pair under this slot and the pair sent before it
  always_comb begin
    pair_idx = slot[3:1] - 3'd2;
    unique case (pair_idx[1:0])
      2'd0: begin
        pair = item.cmd_byte[1:0] & ppe_pkg::PAIR_MASK;
        prev = item.prev_pair;
      end
      2'd1: begin
        pair = item.cmd_byte[3:2] & ppe_pkg::PAIR_MASK;
        prev = item.cmd_byte[1:0];
      end
      2'd2: begin
        pair = item.cmd_byte[5:4] & ppe_pkg::PAIR_MASK;
        prev = item.cmd_byte[3:2];
      end
      default: begin
        pair = item.cmd_byte[7:6] & ppe_pkg::PAIR_MASK;
        prev = item.cmd_byte[5:4];
      end
    endcase
  end

  // ETU counts: first pair of a frame is 3+2p, later ones 7+2(p-q), end-of-frame carrier 8-2p
  always_comb begin
    if (slot == ppe_pkg::SLOT_PAIR0_RUN && !item.started) begin
      pair_etus = ppe_pkg::FIRST_BASE_ETUS + {1'b0, pair, 1'b0};
    end else begin
      pair_etus = ppe_pkg::PAIR_BASE_ETUS + {1'b0, pair, 1'b0} - {1'b0, prev, 1'b0};
    end
    eof_etus = ppe_pkg::EOF_BASE_ETUS - {1'b0, item.cmd_byte[7:6], 1'b0};
  end

  assign pair_samples = ppe_pkg::ETU_SAMPLES[pair_etus];
  assign eof_samples  = ppe_pkg::ETU_SAMPLES[eof_etus];
  assign sof_samples  = ppe_pkg::ETU_SAMPLES[ppe_pkg::SOF_ETUS];
  assign tail_samples = ppe_pkg::ETU_SAMPLES[ppe_pkg::EOF_TAIL_ETUS];

  // Run value and length by slot
  always_comb begin
    run.frame_end = (slot == ppe_pkg::SLOT_EOF_CARRIER1);
    run.run_last  = is_last;
    unique case (slot)
      ppe_pkg::SLOT_HEADER: begin
        run.sample_value = ppe_pkg::SV_HEADER;
        run.run_length   = ppe_pkg::HEADER_LEN;
      end
      ppe_pkg::SLOT_SOF_CARRIER: begin
        run.sample_value = ppe_pkg::SV_CARRIER;
        run.run_length   = sof_samples[4:0];
      end
      ppe_pkg::SLOT_PAIR0_RUN, ppe_pkg::SLOT_PAIR1_RUN,
      ppe_pkg::SLOT_PAIR2_RUN, ppe_pkg::SLOT_PAIR3_RUN: begin
        run.sample_value = ppe_pkg::SV_CARRIER;
        run.run_length   = pair_samples[4:0];
      end
      ppe_pkg::SLOT_EOF_CARRIER0: begin
        run.sample_value = ppe_pkg::SV_CARRIER;
        run.run_length   = eof_samples[4:0];
      end
      ppe_pkg::SLOT_EOF_CARRIER1: begin
        run.sample_value = ppe_pkg::SV_CARRIER;
        run.run_length   = tail_samples[4:0];
      end
      default: begin
        // every odd slot is a pause
        run.sample_value = ppe_pkg::SV_PAUSE;
        run.run_length   = ppe_pkg::PAUSE_LEN;
      end
    endcase
  end

endmodule
